[design/cbz_pkg.sv]
// Shared constants, types and helpers for the cubic Bezier evaluator.
package cbz_pkg;

    localparam int CONTROL_POINTS_DEF = 4;
    localparam int CoordW = 32;
    localparam int TW = 17;
    localparam int AngW = 16;
    localparam int CordicStages = 16;
    localparam int CfgIdxW = 3;
    localparam logic [16:0] TOne = 17'd65536;
    localparam logic signed [19:0] AngleLimit = 20'sd25736;
    localparam logic signed [19:0] PiHalfQ16 = 20'sd102944;

    localparam logic [CfgIdxW-1:0] REG_START_X = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_START_Y = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_CTRL1_X = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_CTRL1_Y = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_CTRL2_X = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_CTRL2_Y = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_END_X = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_END_Y = 3'd7;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] curvature;
        logic signed [15:0] tangent_angle;
        logic degenerate;
    } result_t;

    typedef struct packed {
        logic signed [31:0] p0x;
        logic signed [31:0] p0y;
        logic signed [31:0] p1x;
        logic signed [31:0] p1y;
        logic signed [31:0] p2x;
        logic signed [31:0] p2y;
        logic signed [31:0] p3x;
        logic signed [31:0] p3y;
    } ctrl_pts_t;

    function automatic logic signed [16:0] atan_q16(input int idx);
        logic signed [16:0] r;
        begin
            case (idx)
                0: r = 17'sd51472;
                1: r = 17'sd30386;
                2: r = 17'sd16055;
                3: r = 17'sd8150;
                4: r = 17'sd4091;
                5: r = 17'sd2047;
                6: r = 17'sd1024;
                7: r = 17'sd512;
                8: r = 17'sd256;
                9: r = 17'sd128;
                10: r = 17'sd64;
                11: r = 17'sd32;
                12: r = 17'sd16;
                13: r = 17'sd8;
                14: r = 17'sd4;
                15: r = 17'sd2;
                default: r = 17'sd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        begin
            if (v > 40'sd2147483647)
            begin
                return 32'sh7fffffff;
            end
            if (v < -40'sd2147483648)
            begin
                return 32'sh80000000;
            end
            return v[31:0];
        end
    endfunction

endpackage

[design/cbz_if.sv]
// Valid/ready channel interfaces for parameter, result and configuration.
interface cbz_t_if;
    import cbz_pkg::*;
    logic valid;
    logic ready;
    logic [TW-1:0] t_param;
    modport source (output valid, output t_param, input ready);
    modport sink (input valid, input t_param, output ready);
endinterface

interface cbz_res_if;
    import cbz_pkg::*;
    logic valid;
    logic ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cbz_cfg_if;
    import cbz_pkg::*;
    logic valid;
    logic ready;
    logic [CfgIdxW-1:0] index;
    logic [31:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

[design/cbz_blend.sv]
// Combinational de Casteljau blend a + round((b - a) * t).
module cbz_blend
    import cbz_pkg::*;
#(
    parameter int W = 36
) (
    input  logic signed [W-1:0] a,
    input  logic signed [W-1:0] b,
    input  logic        [16:0]  t,
    output logic signed [W-1:0] y
);
    logic signed [W:0] diff;
    logic signed [W+18:0] prod;
    always_comb
    begin
        diff = (W+1)'(b) - (W+1)'(a);
        prod = (W+19)'(diff) * $signed({2'b00, t}) + (W+19)'(32768);
        y = a + W'(prod >>> 16);
    end
endmodule

[design/cbz_div.sv]
// Pipelined restoring divider for the curvature quotient, one bit per stage.
module cbz_div
    import cbz_pkg::*;
#(
    parameter int NW = 96,
    parameter int DW = 96,
    parameter int QW = 33,
    parameter int TAGW = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [NW-1:0]   num,
    input  logic [DW-1:0]   den,
    input  logic [TAGW-1:0] tag_in,
    output logic            out_valid,
    output logic [QW-1:0]   quo,
    output logic [TAGW-1:0] tag_out
);
    // Quotient bits above QW-1 only feed saturation: pre-check handles them.
    logic [NW-1:0]   num_reg [QW+1];
    logic [DW:0]     rem_reg [QW+1];
    logic [DW-1:0]   den_reg [QW+1];
    logic [QW-1:0]   q_reg   [QW+1];
    logic [TAGW-1:0] tag_reg [QW+1];
    logic            v_reg   [QW+1];

    always_comb
    begin
        num_reg[0] = num;
        den_reg[0] = den;
        tag_reg[0] = tag_in;
        v_reg[0] = in_valid;
        rem_reg[0] = (DW+1)'(num[NW-1:QW]);
        q_reg[0] = '0;
    end

    genvar s;
    generate
        for (s = 0; s < QW; s++)
        begin : g_st
            logic [DW:0] rsh;
            logic [DW+1:0] sub;
            always_comb
            begin
                rsh = {rem_reg[s][DW-1:0], num_reg[s][QW-1-s]};
                sub = {1'b0, rsh} - {2'b00, den_reg[s]};
            end
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[s+1] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[s+1] <= v_reg[s];
                end
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    num_reg[s+1] <= num_reg[s];
                    den_reg[s+1] <= den_reg[s];
                    tag_reg[s+1] <= tag_reg[s];
                    rem_reg[s+1] <= sub[DW+1] ? rsh : sub[DW:0];
                    q_reg[s+1] <= {q_reg[s][QW-2:0], ~sub[DW+1]};
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[QW];
    assign quo = q_reg[QW];
    assign tag_out = tag_reg[QW];
endmodule

[design/cbz_cordic.sv]
// Pipelined vectoring CORDIC for the tangent angle.
module cbz_cordic
    import cbz_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic signed [33:0] ux_in,
    input  logic signed [33:0] uy_in,
    input  logic signed [19:0] acc_in,
    output logic signed [15:0] angle
);
    logic signed [35:0] x_reg [CordicStages+1];
    logic signed [35:0] y_reg [CordicStages+1];
    logic signed [19:0] a_reg [CordicStages+1];

    always_comb
    begin
        x_reg[0] = 36'(ux_in);
        y_reg[0] = 36'(uy_in);
        a_reg[0] = acc_in;
    end

    genvar s;
    generate
        for (s = 0; s < CordicStages; s++)
        begin : g_st
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (!y_reg[s][35])
                    begin
                        x_reg[s+1] <= x_reg[s] + (y_reg[s] >>> s);
                        y_reg[s+1] <= y_reg[s] - (x_reg[s] >>> s);
                        a_reg[s+1] <= a_reg[s] + 20'(atan_q16(s));
                    end
                    else
                    begin
                        x_reg[s+1] <= x_reg[s] - (y_reg[s] >>> s);
                        y_reg[s+1] <= y_reg[s] + (x_reg[s] >>> s);
                        a_reg[s+1] <= a_reg[s] - 20'(atan_q16(s));
                    end
                end
            end
        end
    endgenerate

    logic signed [19:0] rnd;
    always_comb
    begin
        rnd = (a_reg[CordicStages] + 20'sd4) >>> 3;
        if (rnd > AngleLimit)
        begin
            angle = 16'(AngleLimit);
        end
        else if (rnd < -AngleLimit)
        begin
            angle = 16'(-AngleLimit);
        end
        else
        begin
            angle = rnd[15:0];
        end
    end
endmodule

[design/cubic_bezier_point_and_curvature.sv]
// Top level: pipelined cubic Bezier point, derivative, curvature and angle.
// Path: blend and product stages, square root, denominator stages, divider, then the
// output register that holds the result.
// Throughput: one parameter per cycle; the bit-per-stage root and divider
// pipelines set the depth. A stalled output holds the whole pipeline.
// Reset clears control points to zero and all valid bits; payload is not reset.
module cubic_bezier_point_and_curvature
    import cbz_pkg::*;
#(
    parameter int CONTROL_POINTS = CONTROL_POINTS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    cbz_t_if.sink     t_in,
    cbz_res_if.source res_out,
    cbz_cfg_if.sink   cfg
);
    localparam int SqL = 33;
    localparam int DvL = 33;
    localparam int L = 4 + SqL + 2 + DvL;
    localparam int AngDly = DvL - CordicStages + 1;

    ctrl_pts_t pts_reg;
    logic en;
    logic out_v_reg;
    result_t out_reg;
    logic v_pipe;

    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pts_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_START_X: pts_reg.p0x <= cfg.wdata;
                REG_START_Y: pts_reg.p0y <= cfg.wdata;
                REG_CTRL1_X: pts_reg.p1x <= cfg.wdata;
                REG_CTRL1_Y: pts_reg.p1y <= cfg.wdata;
                REG_CTRL2_X: pts_reg.p2x <= cfg.wdata;
                REG_CTRL2_Y: pts_reg.p2y <= cfg.wdata;
                REG_END_X: pts_reg.p3x <= cfg.wdata;
                REG_END_Y: pts_reg.p3y <= cfg.wdata;
                default: pts_reg <= pts_reg;
            endcase
        end
    end

    assign en = !out_v_reg || res_out.ready;
    assign t_in.ready = en;

    // valid shift line
    logic [L-1:0] v_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[L-2:0], t_in.valid};
        end
    end
    assign v_pipe = v_reg[L-1];

    // stage 1: first blend level and second-derivative operands
    logic [16:0] t1_reg, t2_reg, t3_reg;
    logic signed [35:0] qx_reg [3], qy_reg [3];
    logic signed [35:0] dax_reg, dbx_reg, day_reg, dby_reg;
    logic [16:0] tc;
    logic signed [35:0] kx [4], ky [4], qx [3], qy [3];
    always_comb
    begin
        tc = (t_in.t_param > TOne) ? TOne : t_in.t_param;
        kx[0] = 36'(pts_reg.p0x); kx[1] = 36'(pts_reg.p1x);
        kx[2] = 36'(pts_reg.p2x); kx[3] = 36'(pts_reg.p3x);
        ky[0] = 36'(pts_reg.p0y); ky[1] = 36'(pts_reg.p1y);
        ky[2] = 36'(pts_reg.p2y); ky[3] = 36'(pts_reg.p3y);
    end
    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_q
            cbz_blend #(.W(36)) u_bx (.a(kx[g]), .b(kx[g+1]), .t(tc), .y(qx[g]));
            cbz_blend #(.W(36)) u_by (.a(ky[g]), .b(ky[g+1]), .t(tc), .y(qy[g]));
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg <= tc;
            qx_reg <= qx;
            qy_reg <= qy;
            dax_reg <= kx[0] - (kx[1] <<< 1) + kx[2];
            dbx_reg <= kx[1] - (kx[2] <<< 1) + kx[3];
            day_reg <= ky[0] - (ky[1] <<< 1) + ky[2];
            dby_reg <= ky[1] - (ky[2] <<< 1) + ky[3];
        end
    end

    // stage 2: second blend level, acceleration blend
    logic signed [35:0] rx0, rx1, ry0, ry1, bax, bay;
    cbz_blend #(.W(36)) u_r0x (.a(qx_reg[0]), .b(qx_reg[1]), .t(t1_reg), .y(rx0));
    cbz_blend #(.W(36)) u_r1x (.a(qx_reg[1]), .b(qx_reg[2]), .t(t1_reg), .y(rx1));
    cbz_blend #(.W(36)) u_r0y (.a(qy_reg[0]), .b(qy_reg[1]), .t(t1_reg), .y(ry0));
    cbz_blend #(.W(36)) u_r1y (.a(qy_reg[1]), .b(qy_reg[2]), .t(t1_reg), .y(ry1));
    cbz_blend #(.W(36)) u_ax (.a(dax_reg), .b(dbx_reg), .t(t1_reg), .y(bax));
    cbz_blend #(.W(36)) u_ay (.a(day_reg), .b(dby_reg), .t(t1_reg), .y(bay));

    logic signed [35:0] rx0_reg, rx1_reg, ry0_reg, ry1_reg;
    logic signed [31:0] ax_reg, ay_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t2_reg <= t1_reg;
            rx0_reg <= rx0; rx1_reg <= rx1; ry0_reg <= ry0; ry1_reg <= ry1;
            ax_reg <= sat32(40'(bax) * 40'sd6);
            ay_reg <= sat32(40'(bay) * 40'sd6);
        end
    end

    // stage 3: point and velocity
    logic signed [35:0] px, py;
    cbz_blend #(.W(36)) u_px (.a(rx0_reg), .b(rx1_reg), .t(t2_reg), .y(px));
    cbz_blend #(.W(36)) u_py (.a(ry0_reg), .b(ry1_reg), .t(t2_reg), .y(py));
    logic signed [31:0] px3_reg, py3_reg, vx3_reg, vy3_reg, ax3_reg, ay3_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t3_reg <= t2_reg;
            px3_reg <= sat32(40'(px));
            py3_reg <= sat32(40'(py));
            vx3_reg <= sat32(40'(rx1_reg - rx0_reg) * 40'sd3);
            vy3_reg <= sat32(40'(ry1_reg - ry0_reg) * 40'sd3);
            ax3_reg <= ax_reg;
            ay3_reg <= ay_reg;
        end
    end

    // stage 4: products
    logic signed [63:0] pa_reg, pb_reg, sxx_reg, syy_reg;
    result_t r4_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg <= vx3_reg * ay3_reg;
            pb_reg <= ax3_reg * vy3_reg;
            sxx_reg <= vx3_reg * vx3_reg;
            syy_reg <= vy3_reg * vy3_reg;
            r4_reg <= '{px3_reg, py3_reg, vx3_reg, vy3_reg, 32'sd0, 16'sd0, 1'b0};
        end
    end

    // stage 5: sum of squares, cross term, angle prenormalize
    logic [63:0] s5_reg;
    logic neg5_reg;
    logic [63:0] mag5_reg;
    result_t r5_reg;
    logic signed [33:0] ux5_reg, uy5_reg;
    logic signed [19:0] acc5_reg;
    logic signed [33:0] nx, ny, ux, uy;
    logic [32:0] ox, mx, my;
    int lz;
    always_comb
    begin
        mx = r4_reg.vel_x[31] ? 33'(-34'(r4_reg.vel_x)) : 33'(r4_reg.vel_x);
        my = r4_reg.vel_y[31] ? 33'(-34'(r4_reg.vel_y)) : 33'(r4_reg.vel_y);
        ox = mx | my;
        // doubling stops once either magnitude reaches 2^30
        lz = 0;
        for (int i = 0; i < 30; i++)
        begin
            if (ox[i])
            begin
                lz = 30 - i;
            end
        end
        if (ox[32:30] != '0)
        begin
            lz = 0;
        end
        nx = 34'(r4_reg.vel_x) <<< lz;
        ny = 34'(r4_reg.vel_y) <<< lz;
        ux = nx;
        uy = ny;
        if (nx < 0)
        begin
            if (ny >= 0)
            begin
                ux = ny;
                uy = -nx;
            end
            else
            begin
                ux = -ny;
                uy = nx;
            end
        end
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_reg <= 64'(sxx_reg) + 64'(syy_reg);
            neg5_reg <= pa_reg < pb_reg;
            mag5_reg <= (pa_reg < pb_reg) ? 64'(pb_reg - pa_reg) : 64'(pa_reg - pb_reg);
            r5_reg <= r4_reg;
            ux5_reg <= ux;
            uy5_reg <= uy;
            acc5_reg <= (nx < 0) ? ((ny >= 0) ? PiHalfQ16 : -PiHalfQ16) : 20'sd0;
        end
    end

    // square root pipeline, one result bit per stage (SqL - 1 stages)
    logic [63:0] sq_rem [SqL];
    logic [31:0] sq_res [SqL];
    logic [63:0] sq_s   [SqL];
    logic [63:0] sq_mag [SqL];
    logic        sq_neg [SqL];
    result_t     sq_r   [SqL];
    logic signed [33:0] sq_ux [SqL];
    logic signed [33:0] sq_uy [SqL];
    logic signed [19:0] sq_ac [SqL];
    always_comb
    begin
        sq_rem[0] = s5_reg;
        sq_res[0] = '0;
        sq_s[0] = s5_reg;
        sq_mag[0] = mag5_reg;
        sq_neg[0] = neg5_reg;
        sq_r[0] = r5_reg;
        sq_ux[0] = ux5_reg;
        sq_uy[0] = uy5_reg;
        sq_ac[0] = acc5_reg;
    end
    generate
        for (g = 0; g < SqL - 1; g++)
        begin : g_sq
            localparam int B = 31 - g;
            logic [65:0] trial;
            always_comb
            begin
                trial = (66'(sq_res[g]) << (B + 1)) + (66'(1) << (2 * B));
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (66'(sq_rem[g]) >= trial)
                    begin
                        sq_rem[g+1] <= sq_rem[g] - 64'(trial);
                        sq_res[g+1] <= sq_res[g] | (32'(1) << B);
                    end
                    else
                    begin
                        sq_rem[g+1] <= sq_rem[g];
                        sq_res[g+1] <= sq_res[g];
                    end
                    sq_s[g+1] <= sq_s[g];
                    sq_mag[g+1] <= sq_mag[g];
                    sq_neg[g+1] <= sq_neg[g];
                    sq_r[g+1] <= sq_r[g];
                    sq_ux[g+1] <= sq_ux[g];
                    sq_uy[g+1] <= sq_uy[g];
                    sq_ac[g+1] <= sq_ac[g];
                end
            end
        end
    endgenerate

    // denominator S*r split into two 32x32 products over two stages
    localparam int LastSq = SqL - 1;
    logic [63:0] plo_reg, phi_reg, s6_reg, mag6_reg;
    logic neg6_reg;
    result_t r6_reg, r7_reg;
    logic [95:0] den7_reg;
    logic [63:0] mag7_reg;
    logic neg7_reg, zero7_reg;
    logic signed [33:0] ux6_reg, uy6_reg;
    logic signed [19:0] ac6_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            plo_reg <= 64'(sq_s[LastSq][31:0]) * 64'(sq_res[LastSq]);
            phi_reg <= 64'(sq_s[LastSq][63:32]) * 64'(sq_res[LastSq]);
            s6_reg <= sq_s[LastSq];
            mag6_reg <= sq_mag[LastSq];
            neg6_reg <= sq_neg[LastSq];
            r6_reg <= sq_r[LastSq];
            ux6_reg <= sq_ux[LastSq];
            uy6_reg <= sq_uy[LastSq];
            ac6_reg <= sq_ac[LastSq];
        end
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den7_reg <= 96'(plo_reg) + (96'(phi_reg) << 32);
            mag7_reg <= mag6_reg;
            neg7_reg <= neg6_reg;
            zero7_reg <= (s6_reg == '0);
            r7_reg <= r6_reg;
        end
    end

    // angle pipeline runs alongside the divider
    logic signed [15:0] ang_w;
    cbz_cordic u_cordic (
        .clk(clk), .rst_n(rst_n), .en(en),
        .ux_in(ux6_reg), .uy_in(uy6_reg), .acc_in(ac6_reg), .angle(ang_w)
    );
    logic signed [15:0] ang_dly [AngDly + 1];
    assign ang_dly[0] = ang_w;
    generate
        for (g = 0; g < AngDly; g++)
        begin : g_ad
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    ang_dly[g+1] <= ang_dly[g];
                end
            end
        end
    endgenerate

    // quotient overflow beyond 33 bits: num >= den * 2^33
    logic ovf;
    assign ovf = ({32'd0, mag7_reg, 32'd0} >= ({den7_reg, 33'd0} >> 1) << 1)
               && (den7_reg[95:63] != '0 ? 1'b0 : 1'b1)
               && ({mag7_reg, 32'd0} >= {den7_reg[62:0], 33'd0});
    localparam int TagW = $bits(result_t) + 3;
    logic [32:0] quo;
    logic [TagW-1:0] tag_o;
    logic dv_v;
    cbz_div #(.NW(96), .DW(96), .QW(33), .TAGW(TagW)) u_div (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v_reg[4 + SqL + 1]),
        .num({mag7_reg, 32'd0}), .den(zero7_reg ? 96'd1 : den7_reg),
        .tag_in({r7_reg, neg7_reg, zero7_reg, ovf}),
        .out_valid(dv_v), .quo(quo), .tag_out(tag_o)
    );

    result_t rf;
    logic nf, zf, of;
    always_comb
    begin
        {rf, nf, zf, of} = tag_o;
        if (zf)
        begin
            rf.curvature = 32'sd0;
            rf.tangent_angle = 16'sd0;
            rf.degenerate = 1'b1;
        end
        else
        begin
            rf.tangent_angle = ang_dly[AngDly];
            if (!nf)
            begin
                rf.curvature = (of || quo > 33'h7fffffff) ? 32'sh7fffffff : quo[31:0];
            end
            else
            begin
                rf.curvature = (of || quo > 33'h80000000) ? 32'sh80000000
                             : 32'(-$signed({1'b0, quo}));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            out_v_reg <= v_pipe;
        end
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= rf;
        end
    end
    assign res_out.valid = out_v_reg;
    assign res_out.data = out_reg;

    always_ff @(posedge clk)
    begin
        if (CONTROL_POINTS != 4)
        begin
            $error("only cubic curves are supported");
        end
    end

    a_div_align: assert property (@(posedge clk) disable iff (!rst_n)
        dv_v == v_reg[L-1]) else $error("divider valid out of step");
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && !res_out.ready |=> out_v_reg && $stable(out_reg))
        else $error("result dropped under stall");
    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && out_reg.degenerate |-> out_reg.curvature == 32'sd0
        && out_reg.tangent_angle == 16'sd0) else $error("degenerate fields");
endmodule
